FILE: rtl/core/frame_deframer_triple_buffer_unit_macros.svh
// Assertion macros for the frame deframer with triple buffer.
// Used by the top level; relies on clk_i and rst_ni in the including module.
`ifndef FRAME_DEFRAMER_TRIPLE_BUFFER_UNIT_MACROS_SVH
`define FRAME_DEFRAMER_TRIPLE_BUFFER_UNIT_MACROS_SVH

// Same-cycle implication, checked only outside reset.
`define FDTB_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked only outside reset.
`define FDTB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/fdtb_pkg.sv
// Shared types, constants and helper functions of the frame deframer.
// No dependencies; imported by every module of the block.
package fdtb_pkg;

  localparam int unsigned NUM_SLOTS = 3;
  localparam int unsigned SLOT_W    = 2;

  localparam logic [SLOT_W-1:0] SLOT_NONE   = 2'd3;
  localparam logic [31:0]       LONG_MAGIC  = 32'h5650_5254;
  localparam logic [23:0]       MAX_LEN_RST = 24'd262144;

  // Header byte positions at which each header word ends.
  localparam logic [3:0] MAGIC_END = 4'd4;
  localparam logic [3:0] LEN_END   = 4'd8;
  localparam logic [3:0] SEQ_END   = 4'd12;

  localparam logic [4:0] LONG_HDR_BYTES  = 5'd16;
  localparam logic [4:0] SHORT_HDR_BYTES = 5'd8;

  typedef enum logic [1:0] {
    CMD_BYTE   = 2'd0,
    CMD_CLAIM  = 2'd1,
    CMD_OPEN   = 2'd2,
    CMD_IGNORE = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    KIND_HEADER   = 3'd0,
    KIND_BODY     = 3'd1,
    KIND_LAST     = 3'd2,
    KIND_CLAIMED  = 3'd3,
    KIND_NONE     = 3'd4,
    KIND_BAD_LEN  = 3'd5,
    KIND_IGNORED  = 3'd6,
    KIND_OPENED   = 3'd7
  } kind_e;

  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] data;
  } q_entry_t;

  typedef struct packed {
    logic     valid;
    q_entry_t entry;
  } q_head_t;

  typedef struct packed {
    kind_e             kind;
    logic [SLOT_W-1:0] slot;
    logic [23:0]       offset;
    logic [7:0]        store_byte;
    logic [23:0]       frame_len;
    logic [31:0]       sequence_res;
    logic [31:0]       event_time_low;
    logic [31:0]       connection_id;
    logic              frame_dropped;
  } res_t;

  typedef struct packed {
    logic [SLOT_W-1:0] receive_slot;
    logic [SLOT_W-1:0] pending_slot;
    logic [SLOT_W-1:0] consumer_slot;
  } slot_status_t;

  // Lowest slot that is neither of the two given ones.
  function automatic logic [SLOT_W-1:0] lowest_free_slot(logic [SLOT_W-1:0] a,
                                                          logic [SLOT_W-1:0] b);
    logic [SLOT_W-1:0] r;
    logic              found;
    r     = '0;
    found = 1'b0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (!found && SLOT_W'(i) != a && SLOT_W'(i) != b) begin
        r     = SLOT_W'(i);
        found = 1'b1;
      end
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/fdtb_front.sv
// Front end of the deframer: accepts requests, classifies the opcode and
// holds them in a two-entry queue. Depends on fdtb_pkg.
module fdtb_front import fdtb_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] opcode_i,
  input  logic [7:0] data_byte_i,
  output q_head_t    head_o,
  input  logic       pop_i
);

  q_entry_t   mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push;
  q_entry_t   entry;

  assign in_ready_o = (cnt_q != 2'd2);
  assign push       = in_valid_i && in_ready_o;

  always_comb begin
    case (opcode_i)
      CMD_BYTE:  entry.cmd = CMD_BYTE;
      CMD_CLAIM: entry.cmd = CMD_CLAIM;
      CMD_OPEN:  entry.cmd = CMD_OPEN;
      default:   entry.cmd = CMD_IGNORE;
    endcase
    entry.data = data_byte_i;
  end

  always_comb begin
    wr_ptr_d = push  ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push} - {1'b0, pop_i};
  end

  assign head_o.valid = (cnt_q != 2'd0);
  assign head_o.entry = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= entry;
    end
  end

endmodule

FILE: rtl/core/fdtb_back.sv
// Back end of the deframer: header parser, body counter, slot ring and the
// registered result stage. Depends on fdtb_pkg.
module fdtb_back import fdtb_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [23:0]  cfg_wdata_i,
  input  q_head_t      head_i,
  output logic         pop_o,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output res_t         res_o,
  output slot_status_t status_o
);

  logic [23:0]       max_len_q;
  logic [SLOT_W-1:0] recv_q, recv_d;
  logic [SLOT_W-1:0] pend_q, pend_d;
  logic [SLOT_W-1:0] cons_q, cons_d;
  logic              open_q, open_d;
  logic [3:0]        hc_q, hc_d;
  logic              long_q, long_d;
  logic [31:0]       ws_q, ws_d;
  logic [23:0]       cur_len_q, cur_len_d;
  logic [31:0]       cur_seq_q, cur_seq_d;
  logic [31:0]       cur_time_q, cur_time_d;
  logic [23:0]       bc_q, bc_d;
  logic [23:0]       pm_len_q, pm_len_d;
  logic [31:0]       pm_seq_q, pm_seq_d;
  logic [31:0]       pm_time_q, pm_time_d;
  logic [31:0]       pm_conn_q, pm_conn_d;
  logic [31:0]       conn_q, conn_d;
  logic              out_valid_q, out_valid_d;
  res_t              res_q, res_d;

  assign pop_o = head_i.valid && (!out_valid_q || out_ready_i);

  always_comb begin
    logic [4:0]  hc_n;
    logic [31:0] ws_n;
    logic [31:0] seq_n;
    logic [31:0] time_n;
    logic        long_n;
    logic [4:0]  total;
    logic [23:0] bc_n;
    logic [7:0]  b;

    recv_d     = recv_q;
    pend_d     = pend_q;
    cons_d     = cons_q;
    open_d     = open_q;
    hc_d       = hc_q;
    long_d     = long_q;
    ws_d       = ws_q;
    cur_len_d  = cur_len_q;
    cur_seq_d  = cur_seq_q;
    cur_time_d = cur_time_q;
    bc_d       = bc_q;
    pm_len_d   = pm_len_q;
    pm_seq_d   = pm_seq_q;
    pm_time_d  = pm_time_q;
    pm_conn_d  = pm_conn_q;
    conn_d     = conn_q;

    b      = head_i.entry.data;
    hc_n   = {1'b0, hc_q} + 5'd1;
    ws_n   = ws_q;
    seq_n  = (hc_q == 4'd0) ? 32'd0 : cur_seq_q;
    time_n = (hc_q == 4'd0) ? 32'd0 : cur_time_q;
    long_n = long_q;
    total  = SHORT_HDR_BYTES;
    bc_n   = bc_q + 24'd1;

    res_d               = '0;
    res_d.kind          = KIND_IGNORED;
    res_d.connection_id = conn_q;

    if (pop_o) begin
      case (head_i.entry.cmd)
        CMD_BYTE: begin
          if (!open_q) begin
            res_d.kind = KIND_IGNORED;
          end else if (cur_len_q != 24'd0) begin
            res_d.slot       = recv_q;
            res_d.offset     = bc_q;
            res_d.store_byte = b;
            if (bc_n != cur_len_q) begin
              res_d.kind = KIND_BODY;
              bc_d       = bc_n;
            end else begin
              res_d.kind = KIND_LAST;
              if (pend_q != SLOT_NONE) begin
                // A frame still waits: reuse its slot and drop it.
                pend_d              = recv_q;
                recv_d              = pend_q;
                res_d.frame_dropped = 1'b1;
              end else begin
                pend_d = recv_q;
                recv_d = lowest_free_slot(recv_q, cons_q);
              end
              pm_len_d           = cur_len_q;
              pm_seq_d           = cur_seq_q;
              pm_time_d          = cur_time_q;
              pm_conn_d          = conn_q;
              res_d.frame_len    = cur_len_q;
              res_d.sequence_res = cur_seq_q;
              res_d.event_time_low = cur_time_q;
              cur_len_d          = 24'd0;
              bc_d               = 24'd0;
            end
          end else begin
            if (hc_q < MAGIC_END) begin
              ws_n = {ws_q[23:0], b};
            end else if (long_q) begin
              if (hc_q < LEN_END) begin
                ws_n = {ws_q[23:0], b};
              end else if (hc_q < SEQ_END) begin
                seq_n = {seq_n[23:0], b};
              end else begin
                time_n = {time_n[23:0], b};
              end
            end else begin
              seq_n = {seq_n[23:0], b};
            end
            if (hc_n == {1'b0, MAGIC_END}) begin
              long_n = (ws_n == LONG_MAGIC);
              if (long_n) begin
                ws_n = 32'd0;
              end
            end
            total      = long_n ? LONG_HDR_BYTES : SHORT_HDR_BYTES;
            cur_seq_d  = seq_n;
            cur_time_d = time_n;
            long_d     = long_n;
            if (hc_n >= total) begin
              hc_d = 4'd0;
              ws_d = 32'd0;
              bc_d = 24'd0;
              if (ws_n == 32'd0 || ws_n > {8'd0, max_len_q}) begin
                // Bad length closes the connection and resets the parser.
                open_d     = 1'b0;
                long_d     = 1'b0;
                cur_len_d  = 24'd0;
                res_d.kind = KIND_BAD_LEN;
              end else begin
                cur_len_d  = ws_n[23:0];
                res_d.kind = KIND_HEADER;
              end
            end else begin
              hc_d       = hc_n[3:0];
              ws_d       = ws_n;
              res_d.kind = KIND_HEADER;
            end
          end
        end
        CMD_CLAIM: begin
          if (pend_q == SLOT_NONE) begin
            res_d.kind = KIND_NONE;
          end else begin
            cons_d               = pend_q;
            pend_d               = SLOT_NONE;
            res_d.kind           = KIND_CLAIMED;
            res_d.slot           = pend_q;
            res_d.frame_len      = pm_len_q;
            res_d.sequence_res   = pm_seq_q;
            res_d.event_time_low = pm_time_q;
            res_d.connection_id  = pm_conn_q;
          end
        end
        CMD_OPEN: begin
          conn_d              = conn_q + 32'd1;
          open_d              = 1'b1;
          hc_d                = 4'd0;
          long_d              = 1'b0;
          ws_d                = 32'd0;
          cur_len_d           = 24'd0;
          bc_d                = 24'd0;
          res_d.kind          = KIND_OPENED;
          res_d.connection_id = conn_q + 32'd1;
        end
        default: begin
          res_d.kind = KIND_IGNORED;
        end
      endcase
    end
  end

  always_comb begin
    if (pop_o) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q   <= MAX_LEN_RST;
      recv_q      <= '0;
      pend_q      <= SLOT_NONE;
      cons_q      <= SLOT_NONE;
      open_q      <= 1'b0;
      hc_q        <= '0;
      long_q      <= 1'b0;
      ws_q        <= '0;
      cur_len_q   <= '0;
      cur_seq_q   <= '0;
      cur_time_q  <= '0;
      bc_q        <= '0;
      pm_len_q    <= '0;
      pm_seq_q    <= '0;
      pm_time_q   <= '0;
      pm_conn_q   <= '0;
      conn_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        max_len_q <= cfg_wdata_i;
      end
      recv_q      <= recv_d;
      pend_q      <= pend_d;
      cons_q      <= cons_d;
      open_q      <= open_d;
      hc_q        <= hc_d;
      long_q      <= long_d;
      ws_q        <= ws_d;
      cur_len_q   <= cur_len_d;
      cur_seq_q   <= cur_seq_d;
      cur_time_q  <= cur_time_d;
      bc_q        <= bc_d;
      pm_len_q    <= pm_len_d;
      pm_seq_q    <= pm_seq_d;
      pm_time_q   <= pm_time_d;
      pm_conn_q   <= pm_conn_d;
      conn_q      <= conn_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

  assign status_o.receive_slot  = recv_q;
  assign status_o.pending_slot  = pend_q;
  assign status_o.consumer_slot = cons_q;

endmodule

FILE: rtl/core/frame_deframer_triple_buffer_unit.sv
// Path: a request goes through the front queue and then the registered result stage.
// Throughput: one request per cycle while results drain, set by the back-end parser
// and the two-entry queue that lets the front keep accepting while a result waits.
// Reset (rst_ni low, asynchronous): queue and result stage empty, no connection
// open, receive slot 0, no pending or claimed slot, max_frame_len = 262144.
`include "frame_deframer_triple_buffer_unit_macros.svh"

// Top level of the frame deframer: front queue, back end and assertions.
// Depends on fdtb_pkg, fdtb_front, fdtb_back and the macro header.
module frame_deframer_triple_buffer_unit import fdtb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [23:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  opcode_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  kind_o,
  output logic [1:0]  slot_o,
  output logic [23:0] offset_o,
  output logic [7:0]  store_byte_o,
  output logic [23:0] frame_len_o,
  output logic [31:0] sequence_res_o,
  output logic [31:0] event_time_low_o,
  output logic [31:0] connection_id_o,
  output logic        frame_dropped_o
);

  // The front only sorts requests by opcode; every decision that depends on
  // the parser or slot ring is made in the back end, one request a cycle unless stalled.
  q_head_t      head;
  logic         pop;
  res_t         res;
  slot_status_t status;
  logic         slots_distinct;
  logic         idle_accept;

  fdtb_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .opcode_i    (opcode_i),
    .data_byte_i (data_byte_i),
    .head_o      (head),
    .pop_i       (pop)
  );

  // The back end pops the queue whenever its result register is free or is
  // being emptied in the same cycle, so a stalled consumer only fills the queue.
  fdtb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res),
    .status_o    (status)
  );

  assign kind_o           = res.kind;
  assign slot_o           = res.slot;
  assign offset_o         = res.offset;
  assign store_byte_o     = res.store_byte;
  assign frame_len_o      = res.frame_len;
  assign sequence_res_o   = res.sequence_res;
  assign event_time_low_o = res.event_time_low;
  assign connection_id_o  = res.connection_id;
  assign frame_dropped_o  = res.frame_dropped;

  // The three slot roles must never overlap; an empty pending role may match
  // an empty consumer role.
  assign slots_distinct = status.receive_slot != status.pending_slot &&
                          status.receive_slot != status.consumer_slot &&
                          (status.pending_slot == SLOT_NONE ||
                           status.pending_slot != status.consumer_slot);

  // A request taken while both the queue and the result stage are free.
  assign idle_accept = in_valid_i && in_ready_o && !head.valid &&
                       (!out_valid_o || out_ready_i);

  `FDTB_ASSERT_IMPL(a_slots_distinct, 1'b1, slots_distinct, "slot roles overlap")

  // The receive slot is always a real slot.
  `FDTB_ASSERT_IMPL(a_recv_valid, 1'b1, status.receive_slot != SLOT_NONE, "receive slot is none")

  // A request entering an empty pipeline passes the queue and then the result register.
  `FDTB_ASSERT_NEXT(a_latency, idle_accept, ##1 out_valid_o, "result missing after idle request")

  // Only a publishing body byte can report a dropped frame.
  `FDTB_ASSERT_IMPL(a_drop_on_last, out_valid_o && frame_dropped_o, kind_o == KIND_LAST, "drop flag outside publish")

endmodule
